@@ design/smsc_pkg.sv @@
// Shared types and constants for the sample statistics block.
package smsc_pkg;

  localparam int ROWS_PER_COLUMN_DEF = 8;
  localparam int MAX_COLUMNS_DEF     = 12;
  localparam int SAMPLE_W  = 24;
  localparam int COUNT_W   = 7;
  localparam int SUM_W     = 31;
  localparam int DEV_W     = 56;
  localparam int SD_W      = 25;
  localparam int STATUS_W  = 3;
  localparam int FRAC_BITS = 12;
  localparam int DIV_W     = 64;

  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ONE     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_SAT     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DROPPED = 3'd4;

  typedef enum logic [3:0] {
    S_LOAD, S_MEAN_GO, S_MEAN_WAIT, S_DEV_RD, S_DEV_ACC, S_VAR_GO, S_VAR_WAIT,
    S_SQRT, S_CV_GO, S_CV_WAIT, S_OUT
  } smsc_state_t;

  typedef struct packed {
    logic load;       // store and accumulate the incoming sample
    logic mean_start; // divide running sum by count
    logic mean_take;
    logic dev_clear;
    logic dev_read;   // issue store read at pass index
    logic dev_acc;    // accumulate squared deviation
    logic var_start;
    logic var_take;
    logic sqrt_start;
    logic cv_start;
    logic cv_take;
    logic out_load;
    logic set_clear;
  } smsc_cmd_t;

  typedef struct packed {
    logic div_done;
    logic sqrt_done;
    logic pass_end;   // last stored sample issued
    logic multi;      // more than one sample
    logic mean_nz;
  } smsc_stat_t;

endpackage

@@ design/smsc_ram.sv @@
// Generic single-port-write, registered-read RAM.
module smsc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 96
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end
endmodule

@@ design/smsc_div.sv @@
// Restoring signed divider, one quotient bit per cycle, truncates toward zero.
module smsc_div
  import smsc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [DIV_W-1:0] dividend,
  input  logic signed [DIV_W-1:0] divisor,
  output logic                    done,
  output logic signed [DIV_W-1:0] quotient
);
  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] q_r, q_nxt;
  logic [DIV_W-1:0] rem_r, rem_nxt;
  logic [DIV_W-1:0] den_r, den_nxt;
  logic             neg_r, neg_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DIV_W:0]   trial;
  logic [DIV_W-1:0] shifted;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shifted  = {rem_r[DIV_W-2:0], q_r[DIV_W-1]};
    trial    = {1'b0, shifted} - {1'b0, den_r};
    if (start) begin
      q_nxt    = dividend[DIV_W-1] ? DIV_W'(-dividend) : dividend;
      den_nxt  = divisor[DIV_W-1] ? DIV_W'(-divisor) : divisor;
      neg_nxt  = dividend[DIV_W-1] ^ divisor[DIV_W-1];
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(DIV_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // remainder stays below divisor; a set remainder MSB means the shifted value overflows, so subtract
      if (!trial[DIV_W] || rem_r[DIV_W-1]) begin
        rem_nxt = trial[DIV_W-1:0];
        q_nxt   = {q_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        q_nxt   = {q_r[DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  assign done     = done_r;
  assign quotient = neg_r ? DIV_W'(-q_r) : q_r;
endmodule

@@ design/smsc_sqrt.sv @@
// Digit-by-digit floor square root, one result bit per cycle.
module smsc_sqrt
  import smsc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DEV_W-1:0] radicand,
  output logic             done,
  output logic [DEV_W/2-1:0] root
);
  localparam int RW    = DEV_W / 2;
  localparam int CNT_W = $clog2(RW + 1);

  logic [DEV_W-1:0] val_r, val_nxt;
  logic [RW+1:0]    rem_r, rem_nxt;
  logic [RW-1:0]    root_r, root_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [RW+1:0]    cur;
  logic [RW+1:0]    tst;

  always_comb begin
    val_nxt  = val_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cur      = {rem_r[RW-1:0], val_r[DEV_W-1:DEV_W-2]};
    tst      = {root_r, 2'b01};
    if (start) begin
      val_nxt  = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = CNT_W'(RW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      val_nxt = {val_r[DEV_W-3:0], 2'b00};
      if (cur >= tst) begin
        rem_nxt  = cur - tst;
        root_nxt = {root_r[RW-2:0], 1'b1};
      end else begin
        rem_nxt  = cur;
        root_nxt = {root_r[RW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    val_r  <= val_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;
endmodule

@@ design/smsc_ctrl.sv @@
// Controller state machine: sequences load, mean, deviation pass, variance, sqrt, cv, output.
module smsc_ctrl
  import smsc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_last,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  smsc_stat_t stat,
  output smsc_cmd_t  cmd
);
  smsc_state_t state_r, state_nxt;
  logic        acc_r;   // read data valid next cycle in the deviation pass
  logic        ovalid_r, ovalid_nxt;
  logic        take;

  assign take = in_valid && !in_stall;
  // output register may be full as long as it drains before the next result
  assign in_stall  = (state_r != S_LOAD) || (in_last && ovalid_r && out_stall);
  assign out_valid = ovalid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_LOAD:      if (take && in_last) state_nxt = S_MEAN_GO;
      S_MEAN_GO:   state_nxt = S_MEAN_WAIT;
      S_MEAN_WAIT: if (stat.div_done) state_nxt = S_DEV_RD;
      S_DEV_RD:    if (stat.pass_end) state_nxt = S_DEV_ACC;
      S_DEV_ACC:   state_nxt = stat.multi ? S_VAR_GO : S_OUT;
      S_VAR_GO:    state_nxt = S_VAR_WAIT;
      S_VAR_WAIT:  if (stat.div_done) state_nxt = S_SQRT;
      S_SQRT:      if (stat.sqrt_done) state_nxt = stat.mean_nz ? S_CV_GO : S_OUT;
      S_CV_GO:     state_nxt = S_CV_WAIT;
      S_CV_WAIT:   if (stat.div_done) state_nxt = S_OUT;
      S_OUT:       if (!ovalid_r || !out_stall) state_nxt = S_LOAD;
      default:     state_nxt = S_LOAD;
    endcase
  end

  always_comb begin
    cmd = '0;
    ovalid_nxt = ovalid_r && out_stall;
    cmd.load = take;
    case (state_r)
      S_MEAN_GO:   cmd.mean_start = 1'b1;
      S_MEAN_WAIT: begin
        cmd.mean_take = stat.div_done;
        cmd.dev_clear = stat.div_done;
      end
      S_DEV_RD:    cmd.dev_read = 1'b1;
      S_VAR_GO:    cmd.var_start = 1'b1;
      S_VAR_WAIT:  begin
        cmd.var_take   = stat.div_done;
        cmd.sqrt_start = stat.div_done;
      end
      S_SQRT:      cmd.cv_start = 1'b0;
      S_CV_GO:     cmd.cv_start = 1'b1;
      S_CV_WAIT:   cmd.cv_take = stat.div_done;
      S_OUT:       if (!ovalid_r || !out_stall) begin
        cmd.out_load  = 1'b1;
        cmd.set_clear = 1'b1;
        ovalid_nxt    = 1'b1;
      end
      default:     ;
    endcase
    cmd.dev_acc = acc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_LOAD;
      acc_r    <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      acc_r    <= cmd.dev_read;
      ovalid_r <= ovalid_nxt;
    end
  end
endmodule

@@ design/smsc_dp.sv @@
// Datapath: sample store, sums, divider and square root units, result register.
module smsc_dp
  import smsc_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  smsc_cmd_t                  cmd,
  output smsc_stat_t                 stat,
  input  logic signed [SAMPLE_W-1:0] in_conc_value,
  output logic [COUNT_W-1:0]         out_sample_count,
  output logic signed [SAMPLE_W-1:0] out_mean_value,
  output logic [SD_W-1:0]            out_std_dev,
  output logic signed [SAMPLE_W-1:0] out_coeff_var,
  output logic [STATUS_W-1:0]        out_status
);
  localparam int DEPTH  = ROWS_PER_COLUMN_DEF * MAX_COLUMNS_DEF;
  localparam int ADDR_W = $clog2(DEPTH);

  logic signed [SUM_W-1:0]    sum_r;
  logic [COUNT_W-1:0]         cnt_r;
  logic                       ovf_r;
  logic [COUNT_W-1:0]         idx_r;
  logic [DEV_W-1:0]           dev_r;
  logic signed [SAMPLE_W-1:0] mean_r;
  logic [DEV_W-1:0]           var_r;
  logic [SD_W-1:0]            sd_r;
  logic signed [SAMPLE_W-1:0] cv_r;
  logic                       sat_r;
  logic                       sqrt_go_r;  // variance is registered in the cycle before sqrt start
  logic [SAMPLE_W-1:0]        rd_data;
  logic                       full;
  logic signed [SAMPLE_W:0]   diff;
  logic [SAMPLE_W:0]          adiff;
  logic                       div_start, div_done;
  logic signed [DIV_W-1:0]    div_a, div_b, div_q;
  logic                       sqrt_done;
  logic [DEV_W/2-1:0]         root;
  logic [SD_W-1:0]            root_sat;
  logic [STATUS_W-1:0]        status;

  assign full = (cnt_r == COUNT_W'(DEPTH));

  smsc_ram #(.WIDTH(SAMPLE_W), .DEPTH(DEPTH)) u_store (
    .clk     (clk),
    .wr_en   (cmd.load && !full),
    .wr_addr (cnt_r[ADDR_W-1:0]),
    .wr_data (in_conc_value),
    .rd_addr (idx_r[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  // one divider shared by mean, variance and cv
  assign div_start = cmd.mean_start || cmd.var_start || cmd.cv_start;
  always_comb begin
    if (cmd.mean_start) begin
      div_a = DIV_W'(sum_r);
      div_b = DIV_W'(cnt_r);
    end else if (cmd.var_start) begin
      div_a = DIV_W'(dev_r);
      div_b = DIV_W'(cnt_r - 1'b1);
    end else begin
      div_a = DIV_W'({sd_r, {FRAC_BITS{1'b0}}});
      div_b = DIV_W'(mean_r);
    end
  end

  smsc_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .dividend(div_a), .divisor(div_b), .done(div_done), .quotient(div_q)
  );

  smsc_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sqrt_go_r), .radicand(var_r),
    .done(sqrt_done), .root(root)
  );

  assign root_sat = (root > (DEV_W/2)'({SD_W{1'b1}})) ? '1 : SD_W'(root);

  assign diff  = (SAMPLE_W+1)'(mean_r) - (SAMPLE_W+1)'(signed'(rd_data));
  assign adiff = diff[SAMPLE_W] ? (SAMPLE_W+1)'(-diff) : (SAMPLE_W+1)'(diff);

  assign stat.div_done  = div_done;
  assign stat.sqrt_done = sqrt_done;
  assign stat.pass_end  = (idx_r + 1'b1 >= cnt_r);
  assign stat.multi     = (cnt_r > COUNT_W'(1));
  assign stat.mean_nz   = (mean_r != '0);

  always_comb begin
    if (ovf_r)                      status = ST_DROPPED;
    else if (!stat.multi)           status = ST_ONE;
    else if (mean_r == '0)          status = ST_ZERO;
    else if (sat_r)                 status = ST_SAT;
    else                            status = ST_OK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) sqrt_go_r <= 1'b0;
    else        sqrt_go_r <= cmd.sqrt_start;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.set_clear) begin
      sum_r <= '0;
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else if (cmd.load) begin
      if (full) ovf_r <= 1'b1;
      else begin
        sum_r <= sum_r + SUM_W'(in_conc_value);
        cnt_r <= cnt_r + 1'b1;
      end
    end
    if (cmd.mean_take) begin
      mean_r <= SAMPLE_W'(div_q);
      sd_r   <= '0;
      cv_r   <= '0;
      sat_r  <= 1'b0;
    end
    if (cmd.dev_clear) begin
      dev_r <= '0;
      idx_r <= '0;
    end else begin
      if (cmd.dev_read) idx_r <= idx_r + 1'b1;
      if (cmd.dev_acc)  dev_r <= dev_r + DEV_W'(adiff * adiff);
    end
    if (cmd.var_take) var_r <= DEV_W'(div_q);
    if (sqrt_done)    sd_r  <= root_sat;
    if (cmd.cv_take) begin
      if (div_q > DIV_W'(8388607)) begin
        cv_r <= 24'sh7FFFFF; sat_r <= 1'b1;
      end else if (div_q < -DIV_W'(8388608)) begin
        cv_r <= 24'sh800000; sat_r <= 1'b1;
      end else cv_r <= SAMPLE_W'(div_q);
    end
    if (cmd.out_load) begin
      out_sample_count <= cnt_r;
      out_mean_value   <= mean_r;
      out_std_dev      <= sd_r;
      out_coeff_var    <= cv_r;
      out_status       <= status;
    end
  end
endmodule

@@ design/sample_mean_sd_cv.sv @@
// Top level of the sample mean / standard deviation / coefficient of variation block.
//
//  channel | ports                                    | direction
//  in      | in_valid, in_stall, in_conc_value, in_last | request into block
//  out     | out_valid, out_stall, out_sample_count, out_mean_value,
//          | out_std_dev, out_coeff_var, out_status   | result out of block
//
// Samples load one per cycle into the store while in_stall is low. On the last
// request the block stops taking input and runs: mean divide, a read pass through
// the store's registered port, variance divide, square root and cv divide; a
// one-sample set skips from the pass to output and a zero mean skips the cv
// divide. The divider is the shared bottleneck. Reset (rst_n, synchronous)
// clears the set and the output valid flag. A stalled result holds in the
// output register while the next set loads; only its closing request waits.
module sample_mean_sd_cv
  import smsc_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] in_conc_value,
  input  logic                       in_last,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [COUNT_W-1:0]         out_sample_count,
  output logic signed [SAMPLE_W-1:0] out_mean_value,
  output logic [SD_W-1:0]            out_std_dev,
  output logic signed [SAMPLE_W-1:0] out_coeff_var,
  output logic [STATUS_W-1:0]        out_status
);
  smsc_cmd_t  cmd;
  smsc_stat_t stat;

  smsc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_last(in_last),
    .in_stall(in_stall), .out_valid(out_valid), .out_stall(out_stall),
    .stat(stat), .cmd(cmd)
  );

  smsc_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .in_conc_value(in_conc_value),
    .out_sample_count(out_sample_count), .out_mean_value(out_mean_value),
    .out_std_dev(out_std_dev), .out_coeff_var(out_coeff_var),
    .out_status(out_status)
  );
endmodule

@@ design/smsc_checker.sv @@
// Port-level checker for the sample statistics block, bound to the top level.
module smsc_checker
  import smsc_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input logic [COUNT_W-1:0]  out_sample_count,
  input logic [SD_W-1:0]     out_std_dev,
  input logic [SAMPLE_W-1:0] out_coeff_var,
  input logic [STATUS_W-1:0] out_status
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_std_dev))
    else $error("result changed under stall");

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_sample_count != '0)
    else $error("empty set reported");

  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_ONE |-> out_std_dev == '0 && out_coeff_var == '0)
    else $error("single sample with nonzero spread");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ST_DROPPED)
    else $error("bad status code");
endmodule

bind sample_mean_sd_cv smsc_checker u_smsc_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_stall(out_stall),
  .out_sample_count(out_sample_count), .out_std_dev(out_std_dev),
  .out_coeff_var(out_coeff_var), .out_status(out_status)
);
